[hw/rtl/kar_pkg.sv]
// Shared types and constants for the keypad auto-repeat block.
// No dependencies; imported by every module of the block.
`default_nettype none

package kar_pkg;

   // Matrix geometry
   localparam int NUM_COLUMNS = 4;
   localparam int NUM_ROWS    = 4;
   localparam int MASK_BITS   = 16;
   localparam int NUM_KEYS    = (NUM_COLUMNS * NUM_ROWS > MASK_BITS) ?
                                MASK_BITS : NUM_COLUMNS * NUM_ROWS;
   // keys that exist in the matrix; bits above are dropped at the front
   localparam logic [MASK_BITS-1:0] KEY_MASK =
      MASK_BITS'((MASK_BITS+1)'((MASK_BITS+1)'(1) << NUM_KEYS) - (MASK_BITS+1)'(1));

   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CNT_W-1:0]     FIRST_DELAY_RST   = 6'd3;
   localparam logic [CNT_W-1:0]     SLOW_INTERVAL_RST = 6'd32;
   localparam logic [CNT_W-1:0]     FAST_INTERVAL_RST = 6'd4;
   localparam logic [MASK_BITS-1:0] REPEAT_EN_RST     = 16'd2039;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_W      = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIRST_DELAY   = 2'd0,
      CSR_SLOW_INTERVAL = 2'd1,
      CSR_FAST_INTERVAL = 2'd2,
      CSR_REPEAT_EN     = 2'd3
   } csr_index_type;

   // one classified scan
   typedef struct packed {
      logic [MASK_BITS-1:0] pressed;
      logic                 any_pressed;
   } scan_type;

   // configuration seen by the key engine
   typedef struct packed {
      logic [CNT_W-1:0]     first_delay;
      logic [CNT_W-1:0]     slow_interval;
      logic [CNT_W-1:0]     fast_interval;
      logic [MASK_BITS-1:0] repeat_en;
   } cfg_type;

endpackage

`default_nettype wire

[hw/rtl/kar_front.sv]
// Front end: takes scan beats, drops keys outside the matrix, flags any press.
// Depends on kar_pkg.
`default_nettype none

module kar_front import kar_pkg::*; (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [MASK_BITS-1:0] req_tdata,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output scan_type                  push_data
);

   logic [MASK_BITS-1:0] keys;

   assign keys       = req_tdata & KEY_MASK;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.pressed     = keys;
      push_data.any_pressed = |keys;
   end

endmodule

`default_nettype wire

[hw/rtl/kar_queue.sv]
// Two-entry queue of classified scans between front and key engine.
// Depends on kar_pkg.
`default_nettype none

module kar_queue import kar_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire scan_type push_data,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output scan_type      pop_data
);

   scan_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/kar_back.sv]
// Key engine: per-key hold counters and intervals, plus the result register.
// Depends on kar_pkg.
`default_nettype none

module kar_back import kar_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       pop_valid,
   output logic            pop_ready,
   input  wire scan_type   pop_data,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic                 first_press_ff [MASK_BITS];
   logic                 first_press_in [MASK_BITS];
   logic [CNT_W-1:0]     hold_ff        [MASK_BITS];
   logic [CNT_W-1:0]     hold_in        [MASK_BITS];
   logic [CNT_W-1:0]     ival_ff        [MASK_BITS];
   logic [CNT_W-1:0]     ival_in        [MASK_BITS];
   logic [MASK_BITS-1:0] fired;
   logic                 step;

   logic                 rsp_valid_ff;
   logic [MASK_BITS-1:0] fired_ff;
   logic                 any_ff;

   assign pop_ready = ~rsp_valid_ff | rsp_tready;
   assign step      = pop_valid & pop_ready;

   // sixteen independent key updates
   always_comb begin
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] half;
      logic             allowed;
      for (int k = 0; k < MASK_BITS; k++) begin
         cnt     = (hold_ff[k] == CNT_MAX) ? CNT_MAX : CNT_W'(hold_ff[k] + 1'b1);
         half    = ival_ff[k] >> 1;
         allowed = first_press_ff[k] | cfg.repeat_en[k];
         fired[k]          = 1'b0;
         first_press_in[k] = first_press_ff[k];
         hold_in[k]        = hold_ff[k];
         ival_in[k]        = ival_ff[k];
         if (pop_data.pressed[k]) begin
            hold_in[k] = cnt;
            if (cnt >= ival_ff[k] && allowed) begin
               fired[k]   = 1'b1;
               hold_in[k] = '0;
               if (first_press_ff[k]) begin
                  first_press_in[k] = 1'b0;
                  ival_in[k]        = cfg.slow_interval;
               end else begin
                  ival_in[k] = (half < cfg.fast_interval) ? cfg.fast_interval : half;
               end
            end
         end else begin
            first_press_in[k] = 1'b1;
            hold_in[k]        = '0;
            ival_in[k]        = cfg.first_delay;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MASK_BITS; k++) begin
            first_press_ff[k] <= 1'b1;
            hold_ff[k]        <= '0;
            ival_ff[k]        <= FIRST_DELAY_RST;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            for (int k = 0; k < MASK_BITS; k++) begin
               first_press_ff[k] <= first_press_in[k];
               hold_ff[k]        <= hold_in[k];
               ival_ff[k]        <= ival_in[k];
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         fired_ff <= fired;
         any_ff   <= pop_data.any_pressed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W-MASK_BITS-1)'(0), any_ff, fired_ff};

endmodule

`default_nettype wire

[hw/rtl/keypad_auto_repeat.sv]
// Top level of the keypad auto-repeat block: CSRs, front end, queue, key engine.
// Depends on kar_pkg, kar_front, kar_queue and kar_back.
`default_nettype none

// Typematic repeat for a scanned 4x4 key matrix. Each req beat is one finished
// scan (pressed mask, bit column*4+row); each scan yields exactly one rsp beat
// with the keys that fired and an any-pressed flag. A key fires once it has
// been held first_delay scans, then after slow_interval scans, then at an
// interval that halves on every repeat but never drops below fast_interval;
// keys clear in repeat_en fire only once per press. Throughput is one beat
// per clock while rsp_tready is high: all sixteen per-key updates happen in
// parallel in the key engine. A scan passes two registers (queue entry, then
// result register); the two-entry queue lets the input take two scans while a
// result waits. CSRs are written through csr_we/csr_addr/csr_wdata and should
// only be changed while no scan is in flight; a new first_delay or interval
// only applies the next time a key loads it.
module keypad_auto_repeat import kar_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // scan input; tdata[15:0] = pressed_mask
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [MASK_BITS-1:0]  req_tdata,
   // result; tdata[15:0] = fired_mask, tdata[16] = any_pressed, rest zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_W-1:0]           rsp_tdata,
   // CSR write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push_valid, push_ready;
   scan_type push_data;
   logic     pop_valid, pop_ready;
   scan_type pop_data;

   // CSR decode; values are truncated to the register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FIRST_DELAY:   cfg_in.first_delay   = csr_wdata[CNT_W-1:0];
            CSR_SLOW_INTERVAL: cfg_in.slow_interval = csr_wdata[CNT_W-1:0];
            CSR_FAST_INTERVAL: cfg_in.fast_interval = csr_wdata[CNT_W-1:0];
            CSR_REPEAT_EN:     cfg_in.repeat_en     = csr_wdata[MASK_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay   <= FIRST_DELAY_RST;
         cfg_ff.slow_interval <= SLOW_INTERVAL_RST;
         cfg_ff.fast_interval <= FAST_INTERVAL_RST;
         cfg_ff.repeat_en     <= REPEAT_EN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: masks keys outside the matrix, computes any-pressed
   kar_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouples the front end from the key engine
   kar_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // per-key state and result register
   kar_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[tb/kar_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for keypad_auto_repeat: follows the CSR port and both streams,
// predicts each scan's fired keys and compares every rsp beat. Needs kar_pkg.
module kar_checker import kar_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [MASK_BITS-1:0]  req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         errors,
   output int                         outstanding,
   output int                         checked
);

   typedef struct packed {
      logic [MASK_BITS-1:0] fired_mask;
      logic                 any_pressed;
   } scan_outcome_type;

   cfg_type          cfg;
   logic             first_press [NUM_KEYS];
   logic [CNT_W-1:0] hold_cnt    [NUM_KEYS];
   logic [CNT_W-1:0] interval    [NUM_KEYS];
   scan_outcome_type fire_outcomes [$];

   function automatic void clear_keys();
      cfg.first_delay   = FIRST_DELAY_RST;
      cfg.slow_interval = SLOW_INTERVAL_RST;
      cfg.fast_interval = FAST_INTERVAL_RST;
      cfg.repeat_en     = REPEAT_EN_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
         first_press[k] = 1'b1;
         hold_cnt[k]    = '0;
         interval[k]    = FIRST_DELAY_RST;
      end
   endfunction

   // one scan through all keys; updates the key state and returns what fires
   function automatic scan_outcome_type advance_keys(input logic [MASK_BITS-1:0] pressed);
      scan_outcome_type r;
      logic             allowed;
      logic [CNT_W-1:0] half;
      r = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (pressed[k]) begin
            allowed = first_press[k] || cfg.repeat_en[k];
            r.any_pressed = 1'b1;
            if (hold_cnt[k] != CNT_MAX)
               hold_cnt[k] = hold_cnt[k] + 1'b1;
            if (hold_cnt[k] >= interval[k] && allowed) begin
               hold_cnt[k] = '0;
               if (first_press[k]) begin
                  first_press[k] = 1'b0;
                  interval[k]    = cfg.slow_interval;
               end else begin
                  half        = interval[k] >> 1;
                  interval[k] = (half < cfg.fast_interval) ? cfg.fast_interval : half;
               end
               r.fired_mask[k] = 1'b1;
            end
         end else begin
            first_press[k] = 1'b1;
            hold_cnt[k]    = '0;
            interval[k]    = cfg.first_delay;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      scan_outcome_type want;
      scan_outcome_type got;
      if (reset) begin
         clear_keys();
         fire_outcomes.delete();
      end else begin
         // compare before predicting: a scan taken now cannot answer now
         if (rsp_tvalid && rsp_tready) begin
            got.fired_mask  = rsp_tdata[MASK_BITS-1:0];
            got.any_pressed = rsp_tdata[MASK_BITS];
            if (fire_outcomes.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp beat, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = fire_outcomes.pop_front();
               checked++;
               if (got.fired_mask !== want.fired_mask) begin
                  errors++;
                  $display("%0t: fired_mask expected %h, actual %h",
                           $time, want.fired_mask, got.fired_mask);
               end
               if (got.any_pressed !== want.any_pressed) begin
                  errors++;
                  $display("%0t: any_pressed expected %b, actual %b",
                           $time, want.any_pressed, got.any_pressed);
               end
               if (rsp_tdata[RSP_W-1:MASK_BITS+1] !== '0) begin
                  errors++;
                  $display("%0t: rsp pad bits expected 0, actual %h",
                           $time, rsp_tdata[RSP_W-1:MASK_BITS+1]);
               end
            end
         end
         if (req_tvalid && req_tready)
            fire_outcomes.push_back(advance_keys(req_tdata));
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_FIRST_DELAY:   cfg.first_delay   = csr_wdata[CNT_W-1:0];
               CSR_SLOW_INTERVAL: cfg.slow_interval = csr_wdata[CNT_W-1:0];
               CSR_FAST_INTERVAL: cfg.fast_interval = csr_wdata[CNT_W-1:0];
               CSR_REPEAT_EN:     cfg.repeat_en     = csr_wdata[MASK_BITS-1:0];
               default: ;
            endcase
         end
      end
      outstanding = fire_outcomes.size();
   end

endmodule

[tb/tb_keypad_auto_repeat.sv]
`timescale 1ns / 1ps
// Top of the keypad_auto_repeat testbench: clock, reset, scan and CSR stimulus,
// rsp backpressure and the verdict. Needs kar_pkg, keypad_auto_repeat, kar_checker.
module tb_keypad_auto_repeat import kar_pkg::*;;

   localparam int NUM_PHASES  = 8;
   localparam int PHASE_SCANS = 105;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [MASK_BITS-1:0]  req_tdata;        // [15:0] pressed_mask
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;        // [15:0] fired_mask, [16] any_pressed
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   errors;
   int   outstanding;
   int   checked;
   int   sent = 0;
   int   settings = 0;
   logic req_quiet = 1'b0;   // no gaps between scans while set
   logic rsp_quiet = 1'b0;   // no rsp stalls while set

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   keypad_auto_repeat dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata
   );

   kar_checker u_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata,
      .errors, .outstanding, .checked
   );

   // One scan beat. Called at a falling edge, returns at a falling edge, so
   // tvalid only ever changes at a falling edge (it stays high on gap 0).
   task automatic send_scan(input logic [MASK_BITS-1:0] scan);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= scan;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent++;
   endtask

   // Hold off until every scan has been answered and the block is fully idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // All four registers, back to back; upper wdata bits of the 6-bit
   // registers carry junk that must be dropped.
   task automatic set_config(input logic [CNT_W-1:0] first_delay,
                             input logic [CNT_W-1:0] slow_interval,
                             input logic [CNT_W-1:0] fast_interval,
                             input logic [MASK_BITS-1:0] repeat_en);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FIRST_DELAY;
      csr_wdata <= {junk[CSR_DATA_W-1:CNT_W], first_delay};
      @(negedge clock);
      csr_addr  <= CSR_SLOW_INTERVAL;
      csr_wdata <= {~junk[CSR_DATA_W-1:CNT_W], slow_interval};
      @(negedge clock);
      csr_addr  <= CSR_FAST_INTERVAL;
      csr_wdata <= {junk[CSR_DATA_W-1:CNT_W], fast_interval};
      @(negedge clock);
      csr_addr  <= CSR_REPEAT_EN;
      csr_wdata <= repeat_en;
      @(negedge clock);
      csr_we    <= 1'b0;
      settings++;
   endtask

   // rsp backpressure: a random stall before each beat, with runs of
   // beats taken with tready held high
   initial begin : rsp_side
      int gap;
      int beats;
      beats = 0;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (beats % 40 == 0)
            rsp_quiet = ($urandom_range(0, 3) == 0);
         gap = rsp_quiet ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
         beats++;
      end
   end

   initial begin : stimulus
      logic [MASK_BITS-1:0] chord;
      logic [MASK_BITS-1:0] scan;
      int                   len;
      int                   pick;
      int                   goal;

      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_FIRST_DELAY;
      csr_wdata  = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset settings: all keys held to the first fire and past
      // it (disabled keys stop after one), lone corner keys, checkerboards
      send_scan('0);
      repeat (5) send_scan('1);
      send_scan('0);
      send_scan(16'h8000);
      send_scan(16'h0001);
      send_scan(16'hAAAA);
      send_scan(16'h5555);
      send_scan('0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            // smallest nonzero values: every held key fires every scan
            0: set_config(6'd1, 6'd1, 6'd1, '1);
            // largest values: counters run up to the saturation point
            1: set_config(6'd63, 6'd63, 6'd63, '1);
            // zero delay and intervals, repeat off: one fire per press
            2: set_config(6'd0, 6'd0, 6'd0, '0);
            // floor above half: interval climbs up to the floor
            3: set_config(6'd2, 6'd10, 6'd50, 16'($urandom));
            // plain halving down to a low floor
            4: set_config(6'd3, 6'd20, 6'd2, 16'hAAAA);
            default: set_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                6'($urandom_range(0, 63)), 16'($urandom));
         endcase
         goal = sent + PHASE_SCANS;
         while (sent < goal) begin
            pick      = $urandom_range(0, 9);
            req_quiet = ($urandom_range(0, 4) == 0);
            if (pick < 7) begin
               // a chord held for a while, with occasional contact chatter;
               // long holds reach the slow repeats and counter saturation
               case ($urandom_range(0, 2))
                  0:       chord = 16'(1) << $urandom_range(0, 15);
                  1:       chord = 16'($urandom) & 16'($urandom);
                  default: chord = 16'($urandom);
               endcase
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                 : $urandom_range(1, 24);
               // keep the phase close to its scan budget
               if (len > goal - sent)
                  len = goal - sent;
               for (int i = 0; i < len; i++) begin
                  scan = chord;
                  if ($urandom_range(0, 15) == 0)
                     scan[$urandom_range(0, 15)] ^= 1'b1;
                  send_scan(scan);
               end
            end else if (pick < 9) begin
               repeat ($urandom_range(1, 4)) send_scan(16'($urandom));
            end else begin
               repeat ($urandom_range(1, 3)) send_scan('0);
            end
            // now and then let the pipe run dry mid-phase
            if ($urandom_range(0, 40) == 0)
               drain();
         end
      end

      drain();
      repeat (6) @(negedge clock);
      $display("Ran %0d scans under %0d register settings; %0d results compared.",
               sent, settings, checked);
      if (errors == 0 && outstanding == 0)
         $display("tb_keypad_auto_repeat passed");
      else
         $display("tb_keypad_auto_repeat failed");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Timeout with %0d results outstanding.", outstanding);
      $display("tb_keypad_auto_repeat failed");
      $finish;
   end

endmodule
